>>> hdl/isqd_pkg.sv
package isqd_pkg;

  localparam int RAD_W  = 31;  // radicand
  localparam int INT_W  = 16;  // floor root of radicand
  localparam int SCL_W  = 29;  // scaled root
  localparam int SRAD_W = 58;  // radicand * 10^(2p)
  localparam int DIG_W  = 3;   // decimal_digits register

  localparam logic [DIG_W-1:0] MAX_DIGITS = 3'd4;

  // one root bit per iteration of each of the two sqrt units
  localparam int SQ_STEPS = SRAD_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);

  // scaling: two multiply-by-ten passes per decimal digit
  localparam int SC_CNT_W = $clog2(2 * 4 + 1);

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [ST_W-1:0] ST_SCALE = 2'd1;
  localparam logic [ST_W-1:0] ST_ROOT  = 2'd2;

endpackage

>>> hdl/isqd_sqrt.sv
module isqd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [isqd_pkg::SRAD_W-1:0] rad,
  output logic                        done,
  output logic [isqd_pkg::SCL_W-1:0]  root
);

  logic [isqd_pkg::SRAD_W-1:0]   rad_r, rad_nxt;
  logic [isqd_pkg::SCL_W+1:0]    rem_r, rem_nxt;
  logic [isqd_pkg::SCL_W-1:0]    root_r, root_nxt;
  logic [isqd_pkg::SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;

  // remainder with the next two radicand bits brought down, and trial value 4*root+1
  logic [isqd_pkg::SCL_W+3:0] trial;
  logic [isqd_pkg::SCL_W+3:0] sub;
  logic [isqd_pkg::SCL_W+3:0] diff;
  logic                       fits;

  assign trial = {rem_r, rad_r[isqd_pkg::SRAD_W-1 -: 2]};
  assign sub   = {2'b00, root_r, 2'b01};
  assign diff  = trial - sub;
  assign fits  = (trial >= sub);

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (load) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = isqd_pkg::SQ_CNT_W'(isqd_pkg::SQ_STEPS);
    end else if (cnt_r != '0) begin
      rad_nxt  = {rad_r[isqd_pkg::SRAD_W-3:0], 2'b00};
      rem_nxt  = fits ? diff[isqd_pkg::SCL_W+1:0] : trial[isqd_pkg::SCL_W+1:0];
      root_nxt = {root_r[isqd_pkg::SCL_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == isqd_pkg::SQ_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hdl/integer_square_root_decimal.sv
// An accepted request runs 2p multiply-by-ten passes, p = saturated decimal_digits, then
// the 29 iterations of the one-bit-per-cycle sqrt units, and then strobes out_valid. A new
// request is accepted only while the block is idle (busy low), not during a computation.
// The result shows for one cycle only; the receiver cannot stall.
// Reset (rst_n, synchronous, active low) idles the block and sets decimal_digits to 2.
module integer_square_root_decimal (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [isqd_pkg::RAD_W-1:0]  in_radicand,
  input  logic                        cfg_we,
  input  logic [isqd_pkg::DIG_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output logic [isqd_pkg::INT_W-1:0]  out_int_root,
  output logic [isqd_pkg::SCL_W-1:0]  out_scaled_root
);

  logic [isqd_pkg::ST_W-1:0]     state_r, state_nxt;
  logic [isqd_pkg::DIG_W-1:0]    digits_r;
  logic [isqd_pkg::DIG_W-1:0]    p_sat;
  logic [isqd_pkg::SC_CNT_W-1:0] scnt_r, scnt_nxt;
  logic [isqd_pkg::RAD_W-1:0]    rad_r, rad_nxt;
  logic [isqd_pkg::SRAD_W-1:0]   scl_r, scl_nxt;
  logic                          load;
  logic                          int_done;
  logic                          scl_done;
  logic [isqd_pkg::SCL_W-1:0]    int_root_w;
  logic [isqd_pkg::SCL_W-1:0]    scl_root_w;
  logic [isqd_pkg::SRAD_W-1:0]   int_rad;

  assign p_sat   = (digits_r > isqd_pkg::MAX_DIGITS) ? isqd_pkg::MAX_DIGITS : digits_r;
  assign busy    = (state_r != isqd_pkg::ST_IDLE);
  assign int_rad = {{(isqd_pkg::SRAD_W-isqd_pkg::RAD_W){1'b0}}, rad_r};

  always_comb begin
    state_nxt = state_r;
    scnt_nxt  = scnt_r;
    rad_nxt   = rad_r;
    scl_nxt   = scl_r;
    load      = 1'b0;
    unique case (state_r)
      isqd_pkg::ST_IDLE: begin
        if (start) begin
          rad_nxt   = in_radicand;
          scl_nxt   = {{(isqd_pkg::SRAD_W-isqd_pkg::RAD_W){1'b0}}, in_radicand};
          scnt_nxt  = {{(isqd_pkg::SC_CNT_W-isqd_pkg::DIG_W-1){1'b0}}, p_sat, 1'b0};
          state_nxt = isqd_pkg::ST_SCALE;
        end
      end
      isqd_pkg::ST_SCALE: begin
        if (scnt_r == '0) begin
          load      = 1'b1;
          state_nxt = isqd_pkg::ST_ROOT;
        end else begin
          // times ten: 8x + 2x
          scl_nxt  = {scl_r[isqd_pkg::SRAD_W-4:0], 3'b000}
                   + {scl_r[isqd_pkg::SRAD_W-2:0], 1'b0};
          scnt_nxt = scnt_r - 1'b1;
        end
      end
      isqd_pkg::ST_ROOT: begin
        if (scl_done) begin
          state_nxt = isqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isqd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= isqd_pkg::ST_IDLE;
      digits_r <= 3'd2;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        digits_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scnt_r <= scnt_nxt;
    rad_r  <= rad_nxt;
    scl_r  <= scl_nxt;
  end

  isqd_sqrt u_int_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .rad   (int_rad),
    .done  (int_done),
    .root  (int_root_w)
  );

  isqd_sqrt u_scl_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .rad   (scl_r),
    .done  (scl_done),
    .root  (scl_root_w)
  );

  // both units start together and run the same count
  assign out_valid       = scl_done & int_done;
  assign out_int_root    = int_root_w[isqd_pkg::INT_W-1:0];
  assign out_scaled_root = scl_root_w;

endmodule
